// ===== rtl/tws_pkg.sv =====
// Shared constants, codes and types for the text window scroller.
// No dependencies; used by tws_tick_timer and text_window_scroller_unit.
package tws_pkg;

  localparam int MAX_TEXT   = 256;
  localparam int TEXT_AW    = $clog2(MAX_TEXT);
  localparam int LEN_W      = TEXT_AW + 1;
  localparam int MAX_WINDOW = 40;
  localparam int WIN_W      = 6;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int DWELL_W    = 16;
  localparam int TICK_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [TICK_W-1:0] TICKS_MAX  = {TICK_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_NUMBER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLUMN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_DWELL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_DWELL    = 3'd4;

  typedef struct packed {
    logic tick;
    logic clear;
    logic use_end;
  } timer_ctl_t;

endpackage

// ===== rtl/tws_tick_timer.sv =====
// Elapsed tick counter with saturation and dwell compare.
// Depends on tws_pkg.
module tws_tick_timer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tws_pkg::timer_ctl_t         ctl,
  input  logic [tws_pkg::DWELL_W-1:0] end_dwell,
  input  logic [tws_pkg::DWELL_W-1:0] mid_dwell,
  output logic                        expired
);

  logic [tws_pkg::TICK_W-1:0]  elapsed_r;
  logic [tws_pkg::TICK_W-1:0]  elapsed_nxt;
  logic [tws_pkg::TICK_W-1:0]  elapsed_inc;
  logic [tws_pkg::DWELL_W-1:0] dwell;

  assign elapsed_inc = (elapsed_r == tws_pkg::TICKS_MAX) ? elapsed_r
                                                         : elapsed_r + 1'b1;
  assign dwell   = ctl.use_end ? end_dwell : mid_dwell;
  assign expired = elapsed_inc > tws_pkg::TICK_W'(dwell);

  always_comb begin
    elapsed_nxt = elapsed_r;
    priority if (ctl.clear) begin
      elapsed_nxt = '0;
    end else if (ctl.tick) begin
      elapsed_nxt = elapsed_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
    end
  end

  a_sat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (elapsed_r == tws_pkg::TICKS_MAX && ctl.tick && !ctl.clear)
      |=> elapsed_r == tws_pkg::TICKS_MAX)
    else $error("elapsed count left saturation");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> elapsed_r == '0)
    else $error("elapsed count not cleared");

  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.tick && !ctl.clear && elapsed_r != tws_pkg::TICKS_MAX)
      |=> elapsed_r == $past(elapsed_r) + 1'b1)
    else $error("elapsed count did not advance");

endmodule

// ===== rtl/text_window_scroller_unit.sv =====
// Text window scroller top level: config registers, text store memory, window emitter.
// Depends on tws_pkg and tws_tick_timer.
// A load without the last flag or a tick that does not step gives no result.
// A window write emits W cells (W = effective window length, 1..40) once the accept
// enters S_EMIT: one cell is read from the one-port text memory per cycle, via rd_data_r.
// Throughput: one item per cycle when idle; busy covers the window write and its drain.
// Synchronous active-low reset clears control state and loads register defaults;
// the text memory is not cleared. Results cannot be stalled by the receiver.
module text_window_scroller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [7:0]                     in_char_value,
  input  logic                           in_last_char,
  output logic                           out_strobe,
  output logic [1:0]                     out_row,
  output logic [6:0]                     out_column,
  output logic [7:0]                     out_glyph,
  output logic                           out_window_end,
  input  logic                           cfg_we,
  input  logic [tws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tws_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [tws_pkg::ROW_W-1:0]   row_r;
  logic [tws_pkg::WIN_W-1:0]   first_col_r;
  logic [tws_pkg::WIN_W-1:0]   win_len_r;
  logic [tws_pkg::DWELL_W-1:0] end_dwell_r;
  logic [tws_pkg::DWELL_W-1:0] mid_dwell_r;

  logic [tws_pkg::CHAR_W-1:0]  text_mem [tws_pkg::MAX_TEXT];
  logic [tws_pkg::CHAR_W-1:0]  rd_data_r;

  logic [tws_pkg::LEN_W-1:0]   load_pos_r, load_pos_nxt;
  logic [tws_pkg::LEN_W-1:0]   text_len_r, text_len_nxt;
  logic [tws_pkg::TEXT_AW-1:0] offset_r, offset_nxt;
  logic [tws_pkg::WIN_W-1:0]   cell_r, cell_nxt;

  logic                        p1_valid_r;
  logic                        p1_pad_r;
  logic                        p1_end_r;
  logic [tws_pkg::COL_W-1:0]   p1_col_r;
  logic [tws_pkg::ROW_W-1:0]   p1_row_r;

  logic                        accept, load_acc, tick_acc, mem_we, emit_go;
  logic                        scrolling, at_end, at_limit, last_cell, expired;
  logic [tws_pkg::WIN_W-1:0]   win_eff;
  logic [tws_pkg::LEN_W-1:0]   limit, rd_idx, load_pos_inc;
  logic [tws_pkg::TEXT_AW-1:0] offset_scroll;
  tws_pkg::timer_ctl_t         timer_ctl;

  always_comb begin
    priority if (win_len_r == '0) begin
      win_eff = tws_pkg::WIN_W'(1);
    end else if (win_len_r > tws_pkg::WIN_W'(tws_pkg::MAX_WINDOW)) begin
      win_eff = tws_pkg::WIN_W'(tws_pkg::MAX_WINDOW);
    end else begin
      win_eff = win_len_r;
    end
  end

  assign busy     = (state_r != S_IDLE) || p1_valid_r;
  assign accept   = start && !busy;
  assign load_acc = accept && (in_opcode == tws_pkg::OP_LOAD);
  assign tick_acc = accept && (in_opcode == tws_pkg::OP_TICK);
  assign mem_we   = load_acc && (load_pos_r < tws_pkg::LEN_W'(tws_pkg::MAX_TEXT));
  assign load_pos_inc = load_pos_r + tws_pkg::LEN_W'(mem_we);

  assign scrolling = text_len_r > tws_pkg::LEN_W'(win_eff);
  assign limit     = text_len_r - tws_pkg::LEN_W'(win_eff);
  assign at_limit  = tws_pkg::LEN_W'(offset_r) >= limit;
  assign at_end    = (offset_r == '0) || at_limit;
  assign offset_scroll = ((offset_r != '0) && at_limit) ? '0 : offset_r + 1'b1;

  assign timer_ctl.tick    = tick_acc;
  assign timer_ctl.clear   = emit_go;
  assign timer_ctl.use_end = at_end;

  tws_tick_timer u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (timer_ctl),
    .end_dwell (end_dwell_r),
    .mid_dwell (mid_dwell_r),
    .expired   (expired)
  );

  assign emit_go = (load_acc && in_last_char) || (tick_acc && scrolling && expired);

  assign rd_idx    = tws_pkg::LEN_W'(offset_r) + tws_pkg::LEN_W'(cell_r);
  assign last_cell = cell_r == (win_eff - 1'b1);

  always_comb begin
    state_nxt    = state_r;
    load_pos_nxt = load_pos_r;
    text_len_nxt = text_len_r;
    offset_nxt   = offset_r;
    cell_nxt     = cell_r;
    unique case (state_r)
      S_IDLE: begin
        if (load_acc) begin
          load_pos_nxt = load_pos_inc;
          if (in_last_char) begin
            text_len_nxt = load_pos_inc;
            load_pos_nxt = '0;
            offset_nxt   = '0;
          end
        end else if (emit_go) begin
          offset_nxt = offset_scroll;
        end
        if (emit_go) begin
          cell_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cell_nxt = cell_r + 1'b1;
        if (last_cell) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_pos_r  <= '0;
      text_len_r  <= '0;
      offset_r    <= '0;
      cell_r      <= '0;
      p1_valid_r  <= 1'b0;
      row_r       <= '0;
      first_col_r <= '0;
      win_len_r   <= tws_pkg::WIN_W'(16);
      end_dwell_r <= tws_pkg::DWELL_W'(1500);
      mid_dwell_r <= tws_pkg::DWELL_W'(300);
    end else begin
      state_r    <= state_nxt;
      load_pos_r <= load_pos_nxt;
      text_len_r <= text_len_nxt;
      offset_r   <= offset_nxt;
      cell_r     <= cell_nxt;
      p1_valid_r <= (state_r == S_EMIT);
      if (cfg_we) begin
        unique case (cfg_index)
          tws_pkg::REG_ROW_NUMBER:   row_r       <= cfg_data[tws_pkg::ROW_W-1:0];
          tws_pkg::REG_FIRST_COLUMN: first_col_r <= cfg_data[tws_pkg::WIN_W-1:0];
          tws_pkg::REG_WINDOW_LEN:   win_len_r   <= cfg_data[tws_pkg::WIN_W-1:0];
          tws_pkg::REG_END_DWELL:    end_dwell_r <= cfg_data;
          tws_pkg::REG_MID_DWELL:    mid_dwell_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_pad_r <= rd_idx >= text_len_r;
    p1_end_r <= last_cell;
    p1_col_r <= tws_pkg::COL_W'(first_col_r) + tws_pkg::COL_W'(cell_r);
    p1_row_r <= row_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[load_pos_r[tws_pkg::TEXT_AW-1:0]] <= in_char_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT) begin
      rd_data_r <= text_mem[rd_idx[tws_pkg::TEXT_AW-1:0]];
    end
  end

  assign out_strobe     = p1_valid_r;
  assign out_row        = p1_row_r;
  assign out_column     = p1_col_r;
  assign out_glyph      = p1_pad_r ? tws_pkg::SPACE_CODE : rd_data_r;
  assign out_window_end = p1_valid_r && p1_end_r;

  a_go_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> state_r == S_EMIT)
    else $error("window write did not start");

  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> cell_r < win_eff)
    else $error("cell counter past window");

  a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && last_cell) |=> out_window_end)
    else $error("window end marker missing");

  a_no_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result while idle");

endmodule
